// ===== hw/rtl/rbth_pkg.sv =====
// Shared types, opcodes and result codes for the region box table.
`timescale 1ns / 1ps

package rbth_pkg;

	// Opcodes of an input item.
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_VERTEX = 3'd1;
	localparam logic [2:0] OP_CLOSE  = 3'd2;
	localparam logic [2:0] OP_HIT    = 3'd3;
	localparam logic [2:0] OP_STRICT = 3'd4;
	localparam logic [2:0] OP_HEIGHT = 3'd5;

	// Status codes of a result item.
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_HIT  = 3'd1;
	localparam logic [2:0] ST_MISS = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_FEW  = 3'd4;

	// Result selections the controller hands to the datapath.
	localparam logic [2:0] RES_OK     = 3'd0;
	localparam logic [2:0] RES_COMMIT = 3'd1;
	localparam logic [2:0] RES_FEW    = 3'd2;
	localparam logic [2:0] RES_FULL   = 3'd3;
	localparam logic [2:0] RES_HIT    = 3'd4;
	localparam logic [2:0] RES_MISS   = 3'd5;

	localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] COORD_MIN = -24'sh800000;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [23:0] coord_x;
		logic signed [23:0] coord_y;
		logic signed [23:0] coord_z;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         region_index;
		logic signed [23:0] surface_height;
	} rsp_t;

	// One stored table entry.
	typedef struct packed {
		logic signed [23:0] min_x;
		logic signed [23:0] max_x;
		logic signed [23:0] min_z;
		logic signed [23:0] max_z;
		logic signed [23:0] surface;
	} box_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       latch;
		logic       count_clear;
		logic       run_restart;
		logic       run_update;
		logic       commit;
		logic       scan_clear;
		logic       scan_issue;
		logic       res_load;
		logic [2:0] res_sel;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic enough_vtx;
		logic table_full;
		logic scan_more;
		logic hit;
	} dp_stat_t;

endpackage

// ===== hw/rtl/rbth_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rbth_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one word per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/rbth_dp.sv =====
// Datapath: running box, region count, box table, scan compare and result register.
`timescale 1ns / 1ps

module rbth_dp
	import rbth_pkg::*;
#(
	parameter int MAX_REGIONS = 64,
	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
	localparam int CW = $clog2(MAX_REGIONS + 1)
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output rsp_t     rsp,
	output logic     done
);

	logic signed [23:0] run_min_x_q, run_max_x_q, run_min_z_q, run_max_z_q;
	logic [1:0]         vcnt_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_addr_q;
	logic [CW-1:0]      cmp_idx_s1;
	logic [2:0]         qop_q;
	logic signed [23:0] qx_q, qy_q, qz_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	box_t               wr_box;
	logic [$bits(box_t)-1:0] ram_rdata;
	box_t               rd_box;
	logic               in_incl, in_strict, hit;
	logic [CW+5:0]      count_ext, cmp_ext;

	// Running box and vertex count, saturating at three.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_x_q <= COORD_MAX;
			run_max_x_q <= COORD_MIN;
			run_min_z_q <= COORD_MAX;
			run_max_z_q <= COORD_MIN;
			vcnt_q      <= 2'd0;
		end else if (cmd.run_restart) begin
			run_min_x_q <= COORD_MAX;
			run_max_x_q <= COORD_MIN;
			run_min_z_q <= COORD_MAX;
			run_max_z_q <= COORD_MIN;
			vcnt_q      <= 2'd0;
		end else if (cmd.run_update) begin
			if (req.coord_x < run_min_x_q) run_min_x_q <= req.coord_x;
			if (req.coord_x > run_max_x_q) run_max_x_q <= req.coord_x;
			if (req.coord_z < run_min_z_q) run_min_z_q <= req.coord_z;
			if (req.coord_z > run_max_z_q) run_max_z_q <= req.coord_z;
			if (vcnt_q != 2'd3) vcnt_q <= vcnt_q + 2'd1;
		end
	end

	// Number of committed regions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_clear) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Query point captured at the start of a scan.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			qop_q <= req.opcode;
			qx_q  <= req.coord_x;
			qy_q  <= req.coord_y;
			qz_q  <= req.coord_z;
		end
	end

	// Scan address counter; the issued index is registered together with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
		end else if (cmd.scan_clear) begin
			scan_addr_q <= '0;
		end else if (cmd.scan_issue) begin
			scan_addr_q <= scan_addr_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) cmp_idx_s1 <= scan_addr_q;
	end

	// Box table: written on commit, read one entry a cycle during a scan.
	assign ram_we   = cmd.commit;
	assign ram_addr = cmd.commit ? count_q[AW-1:0] : scan_addr_q[AW-1:0];
	assign wr_box   = '{min_x: run_min_x_q, max_x: run_max_x_q,
		min_z: run_min_z_q, max_z: run_max_z_q, surface: req.coord_y};

	rbth_ram #(
		.WIDTH($bits(box_t)),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_box),
		.rdata(ram_rdata)
	);

	assign rd_box = box_t'(ram_rdata);

	// Point test against the entry just read.
	assign in_incl = (qx_q >= rd_box.min_x) && (qx_q <= rd_box.max_x) &&
		(qz_q >= rd_box.min_z) && (qz_q <= rd_box.max_z);
	assign in_strict = (qx_q > rd_box.min_x) && (qx_q < rd_box.max_x) &&
		(qz_q > rd_box.min_z) && (qz_q < rd_box.max_z);

	always_comb begin
		case (qop_q)
			OP_STRICT: hit = in_strict;
			OP_HIT:    hit = in_incl && (qy_q <= rd_box.surface);
			default:   hit = in_incl;
		endcase
	end

	assign stat.enough_vtx = (vcnt_q == 2'd3);
	assign stat.table_full = (count_q >= CW'(MAX_REGIONS));
	assign stat.scan_more  = (scan_addr_q < count_q);
	assign stat.hit        = hit;

	// Indexes are reported modulo 64.
	assign count_ext = {6'd0, count_q};
	assign cmp_ext   = {6'd0, cmp_idx_s1};

	// Result register and its one-cycle strobe.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_COMMIT: rsp_q <= '{ST_OK, count_ext[5:0], req.coord_y};
				RES_FEW:    rsp_q <= '{ST_FEW, 6'd0, 24'sd0};
				RES_FULL:   rsp_q <= '{ST_FULL, 6'd0, 24'sd0};
				RES_HIT:    rsp_q <= '{ST_HIT, cmp_ext[5:0], rd_box.surface};
				RES_MISS:   rsp_q <= '{ST_MISS, 6'd0, 24'sd0};
				default:    rsp_q <= '{ST_OK, 6'd0, 24'sd0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/rbth_ctrl.sv =====
// Controller: decodes items and sequences the table scan.
`timescale 1ns / 1ps

module rbth_ctrl
	import rbth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q, state_d;
	logic pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		cmd.res_sel = RES_OK;
		state_d = state_q;
		pend_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op) inside
						OP_CLEAR: begin
							cmd.count_clear = 1'b1;
							cmd.run_restart = 1'b1;
							cmd.res_load    = 1'b1;
						end
						OP_VERTEX: begin
							cmd.run_update = 1'b1;
							cmd.res_load   = 1'b1;
						end
						OP_CLOSE: begin
							// The vertex check takes precedence over a full table.
							cmd.run_restart = 1'b1;
							cmd.res_load    = 1'b1;
							if (!stat.enough_vtx) begin
								cmd.res_sel = RES_FEW;
							end else if (stat.table_full) begin
								cmd.res_sel = RES_FULL;
							end else begin
								cmd.commit  = 1'b1;
								cmd.res_sel = RES_COMMIT;
							end
						end
						OP_HIT, OP_STRICT, OP_HEIGHT: begin
							cmd.latch      = 1'b1;
							cmd.scan_clear = 1'b1;
							state_d        = S_SCAN;
						end
						default: begin
							cmd.res_load = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (pend_q && stat.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HIT;
					state_d      = S_IDLE;
				end else if (stat.scan_more) begin
					cmd.scan_issue = 1'b1;
					pend_d         = 1'b1;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_MISS;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q == S_SCAN);

endmodule

// ===== hw/rtl/region_bbox_table_hit_test.sv =====
// Top level of the region box table with point queries.
`timescale 1ns / 1ps
// Clear, vertex, close and unknown items: result in the cycle after the transfer, busy stays low,
// so such an item can be taken every cycle.
// Queries: the scan reads one table entry per cycle from the single RAM port; the result comes once
// the first hitting entry has been read and compared, or after the last entry on a miss (busy meanwhile).
// Reset clears the region count and the running box; table contents are undefined until written.
// Each result is shown for one cycle with done high; the receiver cannot stall.

module region_bbox_table_hit_test
	import rbth_pkg::*;
#(
	parameter int MAX_REGIONS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rbth_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (req.opcode),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	rbth_dp #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.rsp   (rsp),
		.done  (done)
	);

endmodule
